FILE: rtl/jbf_pkg.sv
// ----------------------------------------------------------------------------
// jbf_pkg
// Types and constants shared by the jitter buffer playout core.
// ----------------------------------------------------------------------------
package jbf_pkg;

  localparam int FRAMES          = 1024;
  localparam int WORDS_PER_FRAME = 20;

  localparam int FRAME_AW = $clog2(FRAMES);
  localparam int PP_W     = FRAME_AW + 1;
  localparam int WIX_W    = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
  localparam int CNT_W    = $clog2(WORDS_PER_FRAME + 2);
  localparam int STORE_AW = $clog2(FRAMES * WORDS_PER_FRAME);

  localparam logic [31:0] PARITY_FLAG = 32'h8000_0000;
  localparam logic [31:0] INDEX_MASK  = 32'h7FFF_FFFF;

  localparam logic CMD_WORD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [1:0] REG_DELAY  = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;

  localparam int DELAY_RST  = 60;
  localparam int PERIOD_RST = 20;

  typedef struct packed {
    logic        cmd;
    logic [31:0] header;
    logic [63:0] payload_word;
    logic        last_word;
  } jbf_in_t;

  typedef struct packed {
    logic [9:0]  frame_index;
    logic [4:0]  word_index;
    logic [63:0] out_word;
    logic        frame_end;
  } jbf_out_t;

  // present entry: bit 1 parity slot, bit 0 frame slot
  typedef logic [1:0] jbf_pres_t;

  function automatic logic [STORE_AW-1:0] store_addr(input logic [FRAME_AW-1:0] frame,
                                                     input logic [CNT_W-1:0] word);
    logic [STORE_AW+CNT_W:0] a;
    a = (STORE_AW+CNT_W+1)'(frame) * (STORE_AW+CNT_W+1)'(WORDS_PER_FRAME)
        + (STORE_AW+CNT_W+1)'(word);
    return a[STORE_AW-1:0];
  endfunction

endpackage

FILE: rtl/jbf_ram.sv
// ----------------------------------------------------------------------------
// jbf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module jbf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/jitter_buffer_xor_fec_playout_core.sv
// ----------------------------------------------------------------------------
// jitter_buffer_xor_fec_playout_core
// Packet staging, XOR pair recovery and in-order frame playout.
// ----------------------------------------------------------------------------
// Sequence: a tick or a packet word is accepted from idle and then runs the
// deadline skip loop, with one presence lookup per examined frame. A committed
// packet is first copied into the frame or parity store and then tried for recovery.
// Playout reads each frame word through the frame store read port and waits
// while the output stalls. After reset a clearing pass wipes the presence memory;
// no transaction is accepted until it ends.
module jitter_buffer_xor_fec_playout_core
  import jbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  jbf_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output jbf_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [13:0] {
    S_CLR     = 14'b00000000000001,
    S_IDLE    = 14'b00000000000010,
    S_CMT_RD  = 14'b00000000000100,
    S_CMT_CHK = 14'b00000000001000,
    S_COPY    = 14'b00000000010000,
    S_RB_RD0  = 14'b00000000100000,
    S_RB_RD1  = 14'b00000001000000,
    S_RB_CHK  = 14'b00000010000000,
    S_RB_RD   = 14'b00000100000000,
    S_RB_WR   = 14'b00001000000000,
    S_SK_RD   = 14'b00010000000000,
    S_SK_CHK  = 14'b00100000000000,
    S_PL_RD   = 14'b01000000000000,
    S_PL_LD   = 14'b10000000000000
  } state_t;

  state_t              state_r;
  logic [15:0]         delay_r;
  logic [9:0]          period_r;
  logic [31:0]         elapsed_r;
  logic [PP_W-1:0]     pp_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    w_r;
  logic [FRAME_AW-1:0] clr_r;
  logic [63:0]         stg_r [WORDS_PER_FRAME];
  logic [FRAME_AW-1:0] idx_r;
  logic                par_r;
  jbf_pres_t           pidx_r;
  logic [FRAME_AW-1:0] b_r;
  jbf_pres_t           pb_r;
  logic [FRAME_AW-1:0] dst_r;
  logic [FRAME_AW-1:0] src_r;
  logic                dst_par_r;
  logic [31:0]         dl_r;
  logic                out_valid_r;
  jbf_out_t            out_r;

  logic                pw_en;
  logic [FRAME_AW-1:0] pw_addr;
  jbf_pres_t           pw_data;
  logic                pr_en;
  logic [FRAME_AW-1:0] pr_addr;
  jbf_pres_t           pr_data;

  logic                fw_en;
  logic [STORE_AW-1:0] fw_addr;
  logic [63:0]         fw_data;
  logic                fr_en;
  logic [STORE_AW-1:0] fr_addr;
  logic [63:0]         fr_data;

  logic                qw_en;
  logic [STORE_AW-1:0] qw_addr;
  logic                qr_en;
  logic [STORE_AW-1:0] qr_addr;
  logic [63:0]         qr_data;

  logic                in_acc;
  logic                out_take;
  logic                out_load;
  logic [30:0]         hdr_idx;
  logic                last_w;
  logic [FRAME_AW-1:0] pp_lo;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_take = out_valid_r && !out_stall;
  assign out_load = (state_r == S_PL_LD) && (!out_valid_r || !out_stall);
  assign hdr_idx  = in_data.header[30:0] & INDEX_MASK[30:0];
  assign last_w   = (w_r == CNT_W'(WORDS_PER_FRAME - 1));
  assign pp_lo    = pp_r[FRAME_AW-1:0];

  jbf_ram #(.WIDTH(2), .DEPTH(FRAMES)) u_pres (
    .clk(clk), .we(pw_en), .waddr(pw_addr), .wdata(pw_data),
    .re(pr_en), .raddr(pr_addr), .rdata(pr_data)
  );

  jbf_ram #(.WIDTH(64), .DEPTH(FRAMES * WORDS_PER_FRAME)) u_frame (
    .clk(clk), .we(fw_en), .waddr(fw_addr), .wdata(fw_data),
    .re(fr_en), .raddr(fr_addr), .rdata(fr_data)
  );

  jbf_ram #(.WIDTH(64), .DEPTH(FRAMES * WORDS_PER_FRAME)) u_parity (
    .clk(clk), .we(qw_en), .waddr(qw_addr), .wdata(stg_r[w_r[WIX_W-1:0]]),
    .re(qr_en), .raddr(qr_addr), .rdata(qr_data)
  );

  // memory port muxing
  always_comb begin
    pw_en   = 1'b0;
    pw_addr = idx_r;
    pw_data = '0;
    pr_en   = 1'b0;
    pr_addr = idx_r;
    fw_en   = 1'b0;
    fw_addr = store_addr(idx_r, w_r);
    fw_data = stg_r[w_r[WIX_W-1:0]];
    fr_en   = 1'b0;
    fr_addr = store_addr(src_r, w_r);
    qw_en   = 1'b0;
    qw_addr = store_addr(idx_r, w_r);
    qr_en   = 1'b0;
    qr_addr = store_addr(b_r, w_r);
    case (state_r)
      S_CLR: begin
        pw_en   = 1'b1;
        pw_addr = clr_r;
      end
      S_CMT_RD: pr_en = 1'b1;
      S_COPY: begin
        fw_en = !par_r;
        qw_en = par_r;
        if (last_w) begin
          pw_en   = 1'b1;
          pw_data = par_r ? {1'b1, pidx_r[0]} : {pidx_r[1], 1'b1};
        end
      end
      S_RB_RD0: begin
        pr_en   = 1'b1;
        pr_addr = b_r;
      end
      S_RB_RD1: begin
        pr_en   = 1'b1;
        pr_addr = b_r + FRAME_AW'(1);
      end
      S_RB_RD: begin
        fr_en = 1'b1;
        qr_en = 1'b1;
      end
      S_RB_WR: begin
        fw_en   = 1'b1;
        fw_addr = store_addr(dst_r, w_r);
        fw_data = qr_data ^ fr_data;
        if (last_w) begin
          pw_en   = 1'b1;
          pw_addr = dst_r;
          pw_data = {dst_par_r, 1'b1};
        end
      end
      S_SK_RD: begin
        pr_en   = (pp_r < PP_W'(FRAMES));
        pr_addr = pp_lo;
      end
      S_PL_RD: begin
        fr_en   = 1'b1;
        fr_addr = store_addr(pp_lo, w_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      delay_r     <= 16'(DELAY_RST);
      period_r    <= 10'(PERIOD_RST);
      elapsed_r   <= '0;
      pp_r        <= '0;
      cnt_r       <= '0;
      w_r         <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DELAY:  delay_r  <= cfg_data;
          REG_PERIOD: period_r <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + FRAME_AW'(1);
          if (clr_r == FRAME_AW'(FRAMES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.cmd == CMD_TICK) begin
              if (elapsed_r != 32'hFFFF_FFFF) begin
                elapsed_r <= elapsed_r + 32'd1;
              end
              state_r <= S_SK_RD;
            end else if (in_data.last_word) begin
              cnt_r <= '0;
              if (cnt_r == CNT_W'(WORDS_PER_FRAME - 1) &&
                  32'(hdr_idx) < 32'(FRAMES)) begin
                state_r <= S_CMT_RD;
              end else begin
                state_r <= S_SK_RD;
              end
            end else begin
              if (cnt_r < CNT_W'(WORDS_PER_FRAME + 1)) begin
                cnt_r <= cnt_r + CNT_W'(1);
              end
              state_r <= S_SK_RD;
            end
          end
        end
        S_CMT_RD: state_r <= S_CMT_CHK;
        S_CMT_CHK: begin
          w_r <= '0;
          if (par_r ? pr_data[1] : pr_data[0]) begin
            state_r <= S_SK_RD;
          end else begin
            state_r <= S_COPY;
          end
        end
        S_COPY: begin
          if (last_w) begin
            if (b_r == FRAME_AW'(FRAMES - 1)) begin
              state_r <= S_SK_RD;
            end else begin
              state_r <= S_RB_RD0;
            end
          end else begin
            w_r <= w_r + CNT_W'(1);
          end
        end
        S_RB_RD0: state_r <= S_RB_RD1;
        S_RB_RD1: state_r <= S_RB_CHK;
        S_RB_CHK: begin
          w_r <= '0;
          if (pb_r[1] && (pb_r[0] != pr_data[0])) begin
            state_r <= S_RB_RD;
          end else begin
            state_r <= S_SK_RD;
          end
        end
        S_RB_RD: state_r <= S_RB_WR;
        S_RB_WR: begin
          if (last_w) begin
            state_r <= S_SK_RD;
          end else begin
            w_r     <= w_r + CNT_W'(1);
            state_r <= S_RB_RD;
          end
        end
        S_SK_RD: begin
          if (pp_r < PP_W'(FRAMES)) begin
            state_r <= S_SK_CHK;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SK_CHK: begin
          w_r <= '0;
          if (pr_data[0]) begin
            state_r <= S_PL_RD;
          end else if (elapsed_r >= dl_r) begin
            // deadline passed: skip the missing frame
            pp_r    <= pp_r + PP_W'(1);
            state_r <= S_SK_RD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PL_RD: state_r <= S_PL_LD;
        S_PL_LD: begin
          if (out_load) begin
            if (last_w) begin
              pp_r    <= pp_r + PP_W'(1);
              state_r <= S_IDLE;
            end else begin
              w_r     <= w_r + CNT_W'(1);
              state_r <= S_PL_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && in_data.cmd == CMD_WORD) begin
      if (cnt_r < CNT_W'(WORDS_PER_FRAME)) begin
        stg_r[cnt_r[WIX_W-1:0]] <= in_data.payload_word;
      end
      if (in_data.last_word) begin
        idx_r <= hdr_idx[FRAME_AW-1:0];
        par_r <= |(in_data.header & PARITY_FLAG);
        b_r   <= |(in_data.header & PARITY_FLAG) ? hdr_idx[FRAME_AW-1:0]
                 : {hdr_idx[FRAME_AW-1:1], 1'b0};
      end
    end
    if (state_r == S_CMT_CHK) begin
      pidx_r <= pr_data;
    end
    if (state_r == S_RB_RD1) begin
      pb_r <= pr_data;
    end
    if (state_r == S_RB_CHK) begin
      if (pb_r[0]) begin
        src_r     <= b_r;
        dst_r     <= b_r + FRAME_AW'(1);
        dst_par_r <= pr_data[1];
      end else begin
        src_r     <= b_r + FRAME_AW'(1);
        dst_r     <= b_r;
        dst_par_r <= pb_r[1];
      end
    end
    if (state_r == S_SK_RD) begin
      dl_r <= 32'(delay_r) + 32'(pp_r) * 32'(period_r);
    end
    if (out_load) begin
      out_r.frame_index <= 10'(pp_r);
      out_r.word_index  <= 5'(w_r);
      out_r.out_word    <= fr_data;
      out_r.frame_end   <= last_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_pp_range: assert property (@(posedge clk) disable iff (!rst_n)
    pp_r <= PP_W'(FRAMES))
    else $error("playout pointer past end");

  a_rb_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RB_WR |-> $past(state_r) == S_RB_RD)
    else $error("recovery write without read");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> in_stall)
    else $error("transaction accepted during clearing pass");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_valid_r |-> !out_stall)
    else $error("output register overwritten while stalled");
`endif

endmodule

FILE: dv/jitter_buffer_xor_fec_playout_core_checker.sv
// ----------------------------------------------------------------------------
// jitter_buffer_xor_fec_playout_core_checker
// Watches the packet, playout and register ports of the playout core, keeps
// its own model of the frame and parity stores, presence bits, staging
// buffer, playout pointer and millisecond clock, and checks every played
// word against the oldest predicted word.
// ----------------------------------------------------------------------------
module jitter_buffer_xor_fec_playout_core_checker
  import jbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  jbf_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  jbf_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          words_due,
  output int          words_played
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [63:0] frm_mem [FRAMES*WORDS_PER_FRAME];
  logic [63:0] par_mem [FRAMES*WORDS_PER_FRAME];
  bit          frm_have [FRAMES];
  bit          par_have [FRAMES];
  logic [63:0] stage_buf [WORDS_PER_FRAME];
  int          stage_cnt = 0;
  int          play_ptr = 0;
  logic [31:0] ms_now = '0;
  logic [15:0] delay_r = 16'(DELAY_RST);
  logic [9:0]  period_r = 10'(PERIOD_RST);

  jbf_out_t    playout_q [$];
  int          n_fail = 0;
  int          n_due = 0;
  int          n_played = 0;

  assign fail_count   = n_fail;
  assign words_due    = n_due;
  assign words_played = n_played;

  task automatic xor_restore(input int unsigned b);
    int unsigned dst;
    int unsigned src;
    if (b + 1 >= FRAMES) return;
    if (!par_have[b]) return;
    if (frm_have[b] && !frm_have[b+1]) begin
      dst = b + 1;
      src = b;
    end else if (!frm_have[b] && frm_have[b+1]) begin
      dst = b;
      src = b + 1;
    end else begin
      return;
    end
    for (int w = 0; w < WORDS_PER_FRAME; w++)
      frm_mem[dst*WORDS_PER_FRAME+w] = par_mem[b*WORDS_PER_FRAME+w] ^
                                       frm_mem[src*WORDS_PER_FRAME+w];
    frm_have[dst] = 1'b1;
  endtask

  task automatic commit_staged(input logic [31:0] hdr);
    logic [31:0] idx;
    idx = hdr & INDEX_MASK;
    if (idx >= FRAMES) return;
    if ((hdr & PARITY_FLAG) != 0) begin
      if (par_have[idx]) return;
      for (int w = 0; w < WORDS_PER_FRAME; w++)
        par_mem[idx*WORDS_PER_FRAME+w] = stage_buf[w];
      par_have[idx] = 1'b1;
      xor_restore(idx);
    end else begin
      if (frm_have[idx]) return;
      for (int w = 0; w < WORDS_PER_FRAME; w++)
        frm_mem[idx*WORDS_PER_FRAME+w] = stage_buf[w];
      frm_have[idx] = 1'b1;
      xor_restore(idx & ~32'd1);
    end
  endtask

  task automatic absorb_item(input jbf_in_t it);
    jbf_out_t o;
    if (it.cmd == CMD_TICK) begin
      if (ms_now != 32'hFFFF_FFFF) ms_now++;
    end else begin
      if (stage_cnt < WORDS_PER_FRAME) stage_buf[stage_cnt] = it.payload_word;
      if (stage_cnt < WORDS_PER_FRAME + 1) stage_cnt++;
      if (it.last_word) begin
        if (stage_cnt == WORDS_PER_FRAME) commit_staged(it.header);
        stage_cnt = 0;
      end
    end
    // skip missing frames whose deadline has passed
    while (play_ptr < FRAMES && !frm_have[play_ptr] &&
           longint'(ms_now) >= longint'(delay_r) + longint'(play_ptr) * longint'(period_r))
      play_ptr++;
    if (play_ptr < FRAMES && frm_have[play_ptr]) begin
      for (int w = 0; w < WORDS_PER_FRAME; w++) begin
        o.frame_index = 10'(play_ptr);
        o.word_index  = 5'(w);
        o.out_word    = frm_mem[play_ptr*WORDS_PER_FRAME+w];
        o.frame_end   = (w == WORDS_PER_FRAME - 1);
        playout_q.push_back(o);
      end
      play_ptr++;
    end
  endtask

  always @(posedge clk) begin
    jbf_out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_played++;
        if (playout_q.size() == 0) begin
          $error("unexpected played word: frame %0d word %0d",
                 out_data.frame_index, out_data.word_index);
          n_fail++;
        end else begin
          e = playout_q.pop_front();
          if (out_data.frame_index !== e.frame_index) begin
            $error("frame_index: expected %0d, got %0d", e.frame_index, out_data.frame_index);
            n_fail++;
          end
          if (out_data.word_index !== e.word_index) begin
            $error("word_index: expected %0d, got %0d", e.word_index, out_data.word_index);
            n_fail++;
          end
          if (out_data.out_word !== e.out_word) begin
            $error("out_word: expected %h, got %h", e.out_word, out_data.out_word);
            n_fail++;
          end
          if (out_data.frame_end !== e.frame_end) begin
            $error("frame_end: expected %0d, got %0d", e.frame_end, out_data.frame_end);
            n_fail++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_DELAY) delay_r = cfg_data;
        else if (cfg_index == REG_PERIOD) period_r = cfg_data[9:0];
      end
      if (in_valid && !in_stall) absorb_item(in_data);
      n_due = playout_q.size();
    end
  end

endmodule

FILE: dv/jitter_buffer_xor_fec_playout_core_tb.sv
// ----------------------------------------------------------------------------
// jitter_buffer_xor_fec_playout_core_tb
// Drives packets, parity packets, malformed packets and millisecond ticks
// into the playout core through several delay/period settings, with random
// gaps and output back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module jitter_buffer_xor_fec_playout_core_tb;
  import jbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_CYC  = 3000;
  localparam int PHASE_ITEMS = 10;
  localparam int HOLD_CYC    = 400;

  bit          clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  jbf_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  jbf_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DELAY;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int words_due;
  int words_played;

  int items_sent = 0;
  int packets_sent = 0;
  int cursor = 0;
  int hold_trig = 0;
  bit no_gaps = 1'b0;

  always #1 clk = ~clk;

  jitter_buffer_xor_fec_playout_core dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data
  );

  jitter_buffer_xor_fec_playout_core_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .words_due, .words_played
  );

  // receiver: random stall runs, plus a long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  int run_left = 0;
  bit run_stall = 1'b0;
  always @(negedge clk) begin
    if (hold_trig != hold_seen) begin
      hold_seen = hold_trig;
      hold_left = HOLD_CYC;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_stall = ($urandom_range(0, 99) < 35);
        if (run_stall)
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        else
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      end
      run_left--;
      out_stall <= run_stall;
    end
  end

  // watchdog: cycles without any accepted transaction
  int idle_cyc = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic push_item(input jbf_in_t it);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_tick();
    jbf_in_t it;
    it.cmd          = CMD_TICK;
    it.header       = $urandom;
    it.payload_word = rand_word();
    it.last_word    = 1'($urandom_range(0, 1));
    push_item(it);
  endtask

  // one packet of nwords words; only the last word carries the real header, and only it counts
  task automatic send_packet(input logic [31:0] hdr, input int nwords);
    jbf_in_t it;
    for (int w = 0; w < nwords; w++) begin
      it.cmd          = CMD_WORD;
      it.header       = (w == nwords - 1) ? hdr : $urandom;
      it.payload_word = rand_word();
      it.last_word    = (w == nwords - 1);
      push_item(it);
    end
    packets_sent++;
  endtask

  task automatic send_frame_pair(input int b);
    case ($urandom_range(0, 3))
      0: begin
        send_packet(32'(b), WORDS_PER_FRAME);
        send_packet(32'(b + 1), WORDS_PER_FRAME);
      end
      1: begin
        // lose the second member, rebuild it from parity
        send_packet(32'(b), WORDS_PER_FRAME);
        send_packet(PARITY_FLAG | 32'(b), WORDS_PER_FRAME);
      end
      2: begin
        send_packet(PARITY_FLAG | 32'(b), WORDS_PER_FRAME);
        send_packet(32'(b + 1), WORDS_PER_FRAME);
      end
      default: begin
        send_packet(32'(b + 1), WORDS_PER_FRAME);
        send_packet(PARITY_FLAG | 32'(b), WORDS_PER_FRAME);
        send_packet(32'(b), WORDS_PER_FRAME);
      end
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (words_due == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_timing(input logic [15:0] dly, input logic [9:0] per);
    settle();
    write_reg(REG_DELAY, dly);
    write_reg(REG_PERIOD, {6'($urandom), per});
  endtask

  task automatic random_phase();
    int start;
    int r;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (cursor > 1018) cursor = 1018;
      if (r < 10) begin
        send_tick();
      end else if (r < 55) begin
        send_frame_pair(cursor);
        cursor += 2;
      end else if (r < 65) begin
        send_packet(32'(cursor), ($urandom_range(0, 1) != 0) ?
                    $urandom_range(1, WORDS_PER_FRAME - 1) :
                    $urandom_range(WORDS_PER_FRAME + 1, WORDS_PER_FRAME + 6));
      end else if (r < 72) begin
        send_packet({1'($urandom), 31'($urandom_range(FRAMES, 32'h7FFF_FFFF))},
                    WORDS_PER_FRAME);
      end else if (r < 80) begin
        // often a duplicate of something already stored
        if (cursor >= 2)
          send_packet(($urandom_range(0, 1) != 0) ? 32'(cursor - 1) :
                      (PARITY_FLAG | 32'(cursor - 2)), WORDS_PER_FRAME);
      end else if (r < 88) begin
        // parity pair starting at cursor+1, odd-aligned whenever cursor is even
        send_packet(PARITY_FLAG | 32'(cursor + 1), WORDS_PER_FRAME);
        send_packet(32'(cursor + 2), WORDS_PER_FRAME);
        cursor += 3;
      end else begin
        cursor++;  // lost frame
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // hold until the clearing pass lets transactions through
    do @(posedge clk); while (in_stall);

    // directed: defaults, extremes and the special cases
    send_packet(32'd0, WORDS_PER_FRAME);
    send_tick();
    send_packet(32'd1, WORDS_PER_FRAME + 3);
    send_packet(PARITY_FLAG | 32'd0, WORDS_PER_FRAME);
    send_packet(PARITY_FLAG | 32'(FRAMES - 1), WORDS_PER_FRAME);
    cursor = 2;

    set_timing(16'hFFFF, 10'd1000);
    hold_trig++;
    random_phase();

    set_timing(16'd100, 10'd1);
    no_gaps = 1'b1;
    random_phase();
    no_gaps = 1'b0;

    set_timing(16'd300, 10'd20);
    hold_trig++;
    repeat (4) send_tick();
    random_phase();

    // zero period: every missing frame is already late, playout runs to the end
    set_timing(16'd0, 10'd0);
    send_packet(32'(cursor), WORDS_PER_FRAME);
    send_tick();

    settle();
    $display("run: %0d transactions in, %0d packets, %0d words played",
             items_sent, packets_sent, words_played);
    $display("covered parity rebuild, drops, duplicates, deadline skips and playout end");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
